// ===== hdl/lvc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lvc_pkg
// Shared widths, codes and types of the local variable init/use checker.
// ============================================================================
package lvc_pkg;

    // field widths
    localparam int OP_W   = 3;
    localparam int POS_W  = 24;
    localparam int VAR_W  = 5;
    localparam int KIND_W = 2;

    // per-scope variable count and mark entry layout
    localparam int CNT_W         = 6;
    localparam int VAR_SLOTS     = 32;
    localparam int MARK_W        = 26;
    localparam int MARK_INIT_BIT = 25;
    localparam int MARK_USED_BIT = 24;

    // default sizing
    localparam int DEF_MAX_NEST = 8;
    localparam int DEF_MAX_VARS = 32;

    // event codes
    localparam logic [OP_W-1:0] OP_ACCESS = 3'd0;
    localparam logic [OP_W-1:0] OP_UNDO   = 3'd1;
    localparam logic [OP_W-1:0] OP_DYN    = 3'd2;
    localparam logic [OP_W-1:0] OP_BEGIN  = 3'd3;
    localparam logic [OP_W-1:0] OP_END    = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ERR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WARN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAULT = 2'd2;

    // one result request from the sequencer to the output stage
    typedef struct packed {
        logic              valid;
        logic [POS_W-1:0]  position;
        logic [KIND_W-1:0] kind;
    } t_emit;

endpackage

// ===== hdl/local_var_init_use_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// local_var_init_use_checker
// Tracks init and use marks of local variables over a stack of function
// scopes and reports reads before init, unused inits and malformed events.
// ============================================================================
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ------------------------------
//  event     in         i_start && !o_busy        i_op i_pos i_var_req i_init_flag
//  result    out        o_valid (one cycle)       o_position o_kind o_last
//
//  Each event first reads the count RAM into a register, then steps through
//  the sequencer. A held access is applied first (checks, mark RAM read,
//  write back); a dynamic variable is applied as an init and then a read,
//  and function end scans the scope with one mark RAM read per variable.
//  Reset is synchronous and clears the sequencer, scope depth and held access;
//  neither RAM is cleared, a scope's count entry is written at function begin.
//  A result is held until the next one of the same event is found or the
//  event ends, then driven for one cycle; the final one comes the cycle after
//  the last busy cycle. The receiver cannot stall.
//
module local_var_init_use_checker #(
    parameter int MAX_NEST = lvc_pkg::DEF_MAX_NEST,
    parameter int MAX_VARS = lvc_pkg::DEF_MAX_VARS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [lvc_pkg::OP_W-1:0]    i_op,
    input  logic [lvc_pkg::POS_W-1:0]   i_pos,
    input  logic [lvc_pkg::VAR_W-1:0]   i_var_req,
    input  logic                        i_init_flag,
    output logic                        o_valid,
    output logic [lvc_pkg::POS_W-1:0]   o_position,
    output logic [lvc_pkg::KIND_W-1:0]  o_kind,
    output logic                        o_last
);
    import lvc_pkg::*;

    localparam int TW  = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
    localparam int DW  = $clog2(MAX_NEST + 1);
    localparam int MD  = MAX_NEST * VAR_SLOTS;
    localparam int MAW = $clog2(MD);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CNT    = 3'd1;
    localparam logic [2:0] S_DISP   = 3'd2;
    localparam logic [2:0] S_AP_CHK = 3'd3;
    localparam logic [2:0] S_AP_RD  = 3'd4;
    localparam logic [2:0] S_AP_UPD = 3'd5;
    localparam logic [2:0] S_SCAN   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    // event phases
    localparam logic [1:0] PH_FLUSH = 2'd0;
    localparam logic [1:0] PH_MAIN  = 2'd1;
    localparam logic [1:0] PH_DYN2  = 2'd2;
    localparam logic [1:0] PH_END   = 2'd3;

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_phase, n_phase;
    logic [OP_W-1:0]   r_op,    n_op;
    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [VAR_W-1:0]  r_var,   n_var;
    logic              r_init,  n_init;
    logic              r_pend_v, n_pend_v;
    logic [POS_W-1:0]  r_pend_pos, n_pend_pos;
    logic [VAR_W-1:0]  r_pend_var, n_pend_var;
    logic              r_pend_init, n_pend_init;
    logic [DW-1:0]     r_depth, n_depth;
    logic [CNT_W-1:0]  r_cnt,   n_cnt;
    logic [POS_W-1:0]  r_a_pos, n_a_pos;
    logic [VAR_W-1:0]  r_a_var, n_a_var;
    logic              r_a_init, n_a_init;
    logic              r_ok,    n_ok;
    logic [MARK_W-1:0] r_mark,  n_mark;
    logic [CNT_W-1:0]  r_idx,   n_idx;
    logic              r_sv,    n_sv;

    logic [TW-1:0]     w_top;
    logic [CNT_W-1:0]  w_lim;
    logic [MARK_W-1:0] w_upd;
    logic              w_upd_err;
    logic              w_flush_op;

    logic              cnt_we;
    logic [TW-1:0]     cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [CNT_W-1:0]  cnt_rdata;
    logic              mk_we;
    logic [MAW-1:0]    mk_waddr;
    logic [MARK_W-1:0] mk_wdata;
    logic [MAW-1:0]    mk_raddr;
    logic [MARK_W-1:0] mk_rdata;

    t_emit             emit;
    logic              flush;

    function automatic logic [MAW-1:0] mk_addr(input logic [TW-1:0] top,
                                               input logic [VAR_W-1:0] v);
        return MAW'({top, v});
    endfunction

    // current scope and scan limit
    assign w_top  = TW'(r_depth - DW'(1));
    assign w_lim  = (r_cnt > CNT_W'(MAX_VARS)) ? CNT_W'(MAX_VARS) : r_cnt;
    assign o_busy = (r_state != S_IDLE);
    assign w_flush_op = (r_op == OP_ACCESS) || (r_op == OP_DYN) ||
                        (r_op == OP_BEGIN)  || (r_op == OP_END);

    // mark update of one applied access
    always_comb begin
        w_upd     = r_mark;
        w_upd_err = 1'b0;
        if (r_a_init) begin
            if (!r_mark[MARK_INIT_BIT]) begin
                w_upd[POS_W-1:0] = r_a_pos;
            end
            w_upd[MARK_INIT_BIT] = 1'b1;
        end else if (r_mark[MARK_INIT_BIT]) begin
            w_upd[MARK_USED_BIT] = 1'b1;
        end else begin
            w_upd_err = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_op        = r_op;
        n_pos       = r_pos;
        n_var       = r_var;
        n_init      = r_init;
        n_pend_v    = r_pend_v;
        n_pend_pos  = r_pend_pos;
        n_pend_var  = r_pend_var;
        n_pend_init = r_pend_init;
        n_depth     = r_depth;
        n_cnt       = r_cnt;
        n_a_pos     = r_a_pos;
        n_a_var     = r_a_var;
        n_a_init    = r_a_init;
        n_ok        = r_ok;
        n_mark      = r_mark;
        n_idx       = r_idx;
        n_sv        = r_sv;
        cnt_we      = 1'b0;
        cnt_waddr   = w_top;
        cnt_wdata   = '0;
        mk_we       = 1'b0;
        mk_waddr    = mk_addr(w_top, r_a_var);
        mk_wdata    = w_upd;
        mk_raddr    = mk_addr(w_top, r_a_var);
        emit        = '0;
        flush       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_op;
                    n_pos   = i_pos;
                    n_var   = i_var_req;
                    n_init  = i_init_flag;
                    n_state = S_CNT;
                end
            end
            S_CNT: begin
                n_cnt   = cnt_rdata;
                n_phase = PH_FLUSH;
                n_state = S_DISP;
            end
            S_DISP: begin
                case (r_phase)
                    PH_FLUSH: begin
                        // apply the held access first
                        n_phase = PH_MAIN;
                        if (w_flush_op && r_pend_v) begin
                            n_a_pos  = r_pend_pos;
                            n_a_var  = r_pend_var;
                            n_a_init = r_pend_init;
                            n_pend_v = 1'b0;
                            n_state  = S_AP_CHK;
                        end
                    end
                    PH_MAIN: begin
                        n_state = S_DONE;
                        case (r_op)
                            OP_ACCESS: begin
                                n_pend_v    = 1'b1;
                                n_pend_pos  = r_pos;
                                n_pend_var  = r_var;
                                n_pend_init = r_init;
                            end
                            OP_UNDO: begin
                                if (r_pend_v) begin
                                    n_pend_v = 1'b0;
                                    if (r_var != r_pend_var || r_pend_init ||
                                        r_depth == '0) begin
                                        emit = '{valid: 1'b1, position: r_pos,
                                                 kind: KIND_FAULT};
                                    end else if ({1'b0, r_var} == r_cnt &&
                                                 r_cnt < CNT_W'(MAX_VARS)) begin
                                        mk_we     = 1'b1;
                                        mk_waddr  = mk_addr(w_top, r_var);
                                        mk_wdata  = {2'b00, r_pend_pos};
                                        cnt_we    = 1'b1;
                                        cnt_wdata = r_cnt + CNT_W'(1);
                                    end
                                end
                            end
                            OP_DYN: begin
                                n_a_pos  = '0;
                                n_a_var  = r_var;
                                n_a_init = 1'b1;
                                n_phase  = PH_DYN2;
                                n_state  = S_AP_CHK;
                            end
                            OP_BEGIN: begin
                                if (r_depth >= DW'(MAX_NEST)) begin
                                    emit = '{valid: 1'b1, position: r_pos,
                                             kind: KIND_FAULT};
                                end else begin
                                    cnt_we    = 1'b1;
                                    cnt_waddr = TW'(r_depth);
                                    cnt_wdata = '0;
                                    n_depth   = r_depth + DW'(1);
                                end
                            end
                            OP_END: begin
                                if (r_depth == '0) begin
                                    emit = '{valid: 1'b1, position: r_pos,
                                             kind: KIND_FAULT};
                                end else begin
                                    n_idx   = '0;
                                    n_sv    = 1'b0;
                                    n_state = S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    PH_DYN2: begin
                        // read half of a dynamic variable, only if init went in
                        n_state = S_DONE;
                        if (r_ok) begin
                            n_a_pos  = '0;
                            n_a_var  = r_var;
                            n_a_init = 1'b0;
                            n_phase  = PH_END;
                            n_state  = S_AP_CHK;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_AP_CHK: begin
                // scope and index checks, append of a fresh entry
                n_ok    = 1'b0;
                n_state = S_DISP;
                if (r_depth == '0) begin
                    emit = '{valid: 1'b1, position: r_a_pos, kind: KIND_FAULT};
                end else if ({1'b0, r_a_var} == r_cnt) begin
                    if (r_cnt >= CNT_W'(MAX_VARS)) begin
                        emit = '{valid: 1'b1, position: r_a_pos, kind: KIND_FAULT};
                    end else begin
                        n_mark    = {2'b00, r_a_pos};
                        cnt_we    = 1'b1;
                        cnt_wdata = r_cnt + CNT_W'(1);
                        n_cnt     = r_cnt + CNT_W'(1);
                        n_state   = S_AP_UPD;
                    end
                end else if ({1'b0, r_a_var} > r_cnt) begin
                    emit = '{valid: 1'b1, position: r_a_pos, kind: KIND_FAULT};
                end else begin
                    n_state = S_AP_RD;
                end
            end
            S_AP_RD: begin
                n_mark  = mk_rdata;
                n_state = S_AP_UPD;
            end
            S_AP_UPD: begin
                mk_we   = 1'b1;
                n_ok    = 1'b1;
                n_state = S_DISP;
                if (w_upd_err) begin
                    emit = '{valid: 1'b1, position: r_a_pos, kind: KIND_ERR};
                end
            end
            S_SCAN: begin
                // issue one read per cycle, check the entry returned by the previous read
                mk_raddr = mk_addr(w_top, r_idx[VAR_W-1:0]);
                if (r_idx < w_lim) begin
                    n_idx = r_idx + CNT_W'(1);
                    n_sv  = 1'b1;
                end else begin
                    n_sv  = 1'b0;
                end
                if (r_sv && mk_rdata[MARK_INIT_BIT] && !mk_rdata[MARK_USED_BIT]) begin
                    emit = '{valid: 1'b1, position: mk_rdata[POS_W-1:0],
                             kind: KIND_WARN};
                end
                if (!(r_idx < w_lim) && !r_sv) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = '0;
                    n_depth   = r_depth - DW'(1);
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                flush   = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_depth  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_depth  <= n_depth;
            r_pend_v <= n_pend_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_phase     <= n_phase;
        r_op        <= n_op;
        r_pos       <= n_pos;
        r_var       <= n_var;
        r_init      <= n_init;
        r_pend_pos  <= n_pend_pos;
        r_pend_var  <= n_pend_var;
        r_pend_init <= n_pend_init;
        r_cnt       <= n_cnt;
        r_a_pos     <= n_a_pos;
        r_a_var     <= n_a_var;
        r_a_init    <= n_a_init;
        r_ok        <= n_ok;
        r_mark      <= n_mark;
        r_idx       <= n_idx;
        r_sv        <= n_sv;
    end

    // per-scope variable counts
    lvc_ram #(
        .W  (CNT_W),
        .D  (MAX_NEST),
        .AW (TW)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (w_top),
        .o_rdata (cnt_rdata)
    );

    // init, used and position marks per variable
    lvc_ram #(
        .W  (MARK_W),
        .D  (MD),
        .AW (MAW)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mk_we),
        .i_waddr (mk_waddr),
        .i_wdata (mk_wdata),
        .i_raddr (mk_raddr),
        .o_rdata (mk_rdata)
    );

    // result stage
    lvc_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_emit     (emit),
        .i_flush    (flush),
        .o_valid    (o_valid),
        .o_position (o_position),
        .o_kind     (o_kind),
        .o_last     (o_last)
    );

    // scope depth stays within the stack
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(MAX_NEST))
        else $error("scope depth beyond stack size");

    // a result only leaves while an event is in work or right at its end
    a_valid_in_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result outside of an event");

    // the last result of an event is never followed at once by another
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result right after last");

    // an accepted event makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted event did not start");

endmodule

// ===== hdl/lvc_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lvc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module lvc_ram #(
    parameter int W  = lvc_pkg::MARK_W,
    parameter int D  = lvc_pkg::DEF_MAX_NEST * lvc_pkg::VAR_SLOTS,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [0:D-1];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/lvc_out_buf.sv =====
`timescale 1ns / 1ps
// ============================================================================
// lvc_out_buf
// Result output stage: holds one result back so the final one of an event
// can be flagged as last, and drives the registered result strobe.
// ============================================================================
module lvc_out_buf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lvc_pkg::t_emit              i_emit,
    input  logic                        i_flush,
    output logic                        o_valid,
    output logic [lvc_pkg::POS_W-1:0]   o_position,
    output logic [lvc_pkg::KIND_W-1:0]  o_kind,
    output logic                        o_last
);
    import lvc_pkg::*;

    logic              r_hold_v;
    logic [POS_W-1:0]  r_hold_pos;
    logic [KIND_W-1:0] r_hold_kind;

    // control: hold flag and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_emit.valid) begin
            r_hold_v <= 1'b1;
            o_valid  <= r_hold_v;
        end else if (i_flush) begin
            r_hold_v <= 1'b0;
            o_valid  <= r_hold_v;
        end else begin
            o_valid  <= 1'b0;
        end
    end

    // payload: the held result moves out when a newer one arrives or at flush
    always_ff @(posedge i_clk) begin
        if (i_emit.valid) begin
            r_hold_pos  <= i_emit.position;
            r_hold_kind <= i_emit.kind;
            o_position  <= r_hold_pos;
            o_kind      <= r_hold_kind;
            o_last      <= 1'b0;
        end else if (i_flush) begin
            o_position  <= r_hold_pos;
            o_kind      <= r_hold_kind;
            o_last      <= 1'b1;
        end
    end

endmodule
